@@ sv/tcep_pkg.sv @@
package tcep_pkg;

    localparam int NAME_CAPACITY_DEF = 64;
    localparam int MAX_ENTRIES_DEF   = 1024;

    localparam logic [31:0] TAG_MAGIC = 32'h424C544D;
    localparam logic [31:0] TAG_NAME  = 32'h454D414E;
    localparam logic [31:0] TAG_TYPE  = 32'h45505954;
    localparam logic [31:0] TAG_OFFT  = 32'h5446464F;
    localparam logic [31:0] TAG_MDSZ  = 32'h5A53444D;
    localparam logic [31:0] TAG_ENDT  = 32'h54444E45;

    localparam logic [32:0] HEADER_END   = 33'h20;
    localparam logic [31:0] TABLE_PTR_AT = 32'h18;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_RANGE     = 4'd3,
        ST_TABLE     = 4'd4,
        ST_CAP       = 4'd5,
        ST_OVERFLOW  = 4'd6,
        ST_TRUNC     = 4'd7,
        ST_IN_HEADER = 4'd8
    } status_t;

    typedef struct packed {
        logic        item_kind;
        logic [9:0]  entry_index;
        logic [31:0] name_offset;
        logic [5:0]  name_length;
        logic [1:0]  stage;
        logic [7:0]  type_byte;
        logic        bitcode_valid;
        logic [63:0] bitcode_offset;
        logic [63:0] bitcode_length;
        logic [3:0]  status;
        logic [10:0] record_count;
    } result_t;

endpackage

@@ sv/tcep_core.sv @@
module tcep_core #(
    parameter int NAME_CAPACITY = tcep_pkg::NAME_CAPACITY_DEF,
    parameter int MAX_ENTRIES   = tcep_pkg::MAX_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       file_length,
    output logic              res_valid,
    output tcep_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_HEADER, PH_SEEK, PH_COUNT, PH_BOUNDARY, PH_HEAD, PH_DATA, PH_DONE
    } phase_t;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [31:0] NAME_MAX = 32'(NAME_CAPACITY - 1);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [63:0] tab_reg, tab_next;
    logic [CW-1:0] total_reg, total_next, done_cnt_reg, done_cnt_next;
    logic [2:0]  fbi_reg, fbi_next;
    logic [31:0] tag_reg, tag_next, flen_reg, flen_next, skip_reg, skip_next;
    logic [63:0] vs_reg, vs_next;
    logic [31:0] nof_reg, nof_next;
    logic [5:0]  nlen_reg, nlen_next;
    logic [7:0]  sraw_reg, sraw_next;
    logic [1:0]  stg_reg, stg_next, seen_reg, seen_next;
    logic [63:0] bco_reg, bco_next, bcs_reg, bcs_next;
    logic        fdone_reg, fdone_next;

    logic        emit;
    tcep_pkg::result_t out_c;

    logic [32:0] len33, pos1;
    logic [31:0] di;
    logic [2:0]  idx;
    logic [31:0] tag_w;
    logic [31:0] flen_w;
    logic [63:0] vs_w;
    logic        fin, rec, stop;
    logic [3:0]  st;
    logic        bc_ok;
    logic [64:0] bc_sum;

    always_comb
    begin
        phase_next = phase_reg; pos_next = pos_reg; tab_next = tab_reg;
        total_next = total_reg; done_cnt_next = done_cnt_reg; fbi_next = fbi_reg;
        tag_next = tag_reg; flen_next = flen_reg; skip_next = skip_reg;
        vs_next = vs_reg; nof_next = nof_reg; nlen_next = nlen_reg;
        sraw_next = sraw_reg; stg_next = stg_reg; seen_next = seen_reg;
        bco_next = bco_reg; bcs_next = bcs_reg; fdone_next = fdone_reg;
        fin = 1'b0; rec = 1'b0; stop = 1'b0; st = tcep_pkg::ST_OK;
        len33 = {1'b0, file_length};
        pos1 = {1'b0, pos_reg} + 33'd1;
        di = flen_reg - skip_reg;
        idx = (phase_reg == PH_BOUNDARY) ? 3'd0 : fbi_reg;
        tag_w = tag_reg; flen_w = flen_reg; vs_w = vs_reg;
        bc_sum = {1'b0, bco_reg} + {1'b0, bcs_reg};
        bc_ok = (seen_reg == 2'b11) && (bc_sum <= {32'd0, len33});
        out_c = '0;
        out_c.entry_index = 10'(done_cnt_reg);
        out_c.name_offset = nof_reg;
        out_c.name_length = nlen_reg;
        out_c.stage = stg_reg;
        out_c.type_byte = sraw_reg;
        out_c.bitcode_valid = bc_ok;
        out_c.bitcode_offset = bc_ok ? bco_reg : 64'd0;
        out_c.bitcode_length = bc_ok ? bcs_reg : 64'd0;

        if (step && !fdone_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == 32'd0 && len33 < tcep_pkg::HEADER_END)
                    begin
                        fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_SHORT;
                    end
                    else
                    begin
                        if (pos_reg < 32'd4)
                        begin
                            tag_w = tag_reg | (32'(data_byte) << {pos_reg[1:0], 3'd0});
                            tag_next = tag_w;
                        end
                        if (pos_reg == 32'd3 && tag_w != tcep_pkg::TAG_MAGIC)
                        begin
                            fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_MAGIC;
                        end
                        else
                        begin
                            if (pos_reg >= tcep_pkg::TABLE_PTR_AT && pos_reg < 32'h20)
                                tab_next = tab_reg |
                                    (64'(data_byte) << {pos_reg[2:0], 3'd0});
                            if (pos_reg >= 32'h1F)
                            begin
                                if (tab_next == 64'd0 || tab_next >= {31'd0, len33})
                                begin
                                    fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_RANGE;
                                end
                                else if (tab_next < 64'h20)
                                begin
                                    fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_IN_HEADER;
                                end
                                else if (tab_next + 64'd4 > {31'd0, len33})
                                begin
                                    fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_TABLE;
                                end
                                else
                                begin
                                    vs_next = '0; fbi_next = '0;
                                    phase_next = (tab_next == 64'h20) ? PH_COUNT : PH_SEEK;
                                end
                            end
                        end
                    end
                end
                PH_SEEK:
                begin
                    if ({31'd0, pos1} >= tab_reg)
                        phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    vs_w = vs_reg | (64'(data_byte) << {fbi_reg[1:0], 3'd0});
                    vs_next = vs_w;
                    fbi_next = fbi_reg + 3'd1;
                    if (fbi_reg == 3'd3)
                    begin
                        fbi_next = '0;
                        if (vs_w > 64'(MAX_ENTRIES))
                        begin
                            fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_CAP;
                        end
                        else
                        begin
                            total_next = CW'(vs_w);
                            nof_next = '0; nlen_next = '0; sraw_next = '0; stg_next = '0;
                            bco_next = '0; bcs_next = '0; seen_next = '0;
                            phase_next = (vs_w == 64'd0) ? PH_DONE : PH_BOUNDARY;
                        end
                    end
                end
                PH_BOUNDARY, PH_HEAD:
                begin
                    phase_next = PH_HEAD;
                    if (idx == 3'd0 && (pos1 + 33'd7) > len33)
                    begin
                        fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_TRUNC;
                    end
                    else
                    begin
                        if (idx == 3'd0)
                        begin
                            tag_w = '0; flen_w = '0;
                        end
                        if (!idx[2])
                            tag_w = tag_w | (32'(data_byte) << {idx[1:0], 3'd0});
                        else
                            flen_w = flen_w | (32'(data_byte) << {idx[1:0], 3'd0});
                        tag_next = tag_w; flen_next = flen_w;
                        if (idx == 3'd3 && tag_w == tcep_pkg::TAG_ENDT)
                        begin
                            rec = 1'b1;
                            done_cnt_next = done_cnt_reg + CW'(1);
                        end
                        if (idx == 3'd7)
                        begin
                            if ({1'b0, pos1} + {1'b0, flen_w} > {1'b0, len33})
                            begin
                                fin = 1'b1; stop = 1'b1; st = tcep_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                if (tag_w == tcep_pkg::TAG_NAME)
                                begin
                                    nof_next = pos1[31:0];
                                    nlen_next = ((flen_w >= 32'(NAME_CAPACITY)) ?
                                                 NAME_MAX[5:0] : flen_w[5:0]);
                                end
                                vs_next = '0;
                                skip_next = flen_w;
                                fbi_next = '0;
                                if (flen_w == 32'd0)
                                begin
                                    if (tag_w == tcep_pkg::TAG_ENDT)
                                    begin
                                        nof_next = '0; nlen_next = '0; sraw_next = '0;
                                        stg_next = '0; bco_next = '0; bcs_next = '0;
                                        seen_next = '0;
                                        phase_next = (done_cnt_next >= total_reg) ?
                                                     PH_DONE : PH_BOUNDARY;
                                    end
                                    else
                                        phase_next = PH_HEAD;
                                end
                                else
                                    phase_next = PH_DATA;
                            end
                        end
                        else
                            fbi_next = idx + 3'd1;
                    end
                end
                PH_DATA:
                begin
                    if (tag_reg == tcep_pkg::TAG_TYPE && di == 32'd0)
                    begin
                        sraw_next = data_byte;
                        stg_next = (data_byte >= 8'd1 && data_byte <= 8'd3) ?
                                   data_byte[1:0] : 2'd0;
                    end
                    else if ((tag_reg == tcep_pkg::TAG_OFFT ||
                              tag_reg == tcep_pkg::TAG_MDSZ) &&
                             flen_reg >= 32'd8 && di < 32'd8)
                    begin
                        vs_w = vs_reg | (64'(data_byte) << {di[2:0], 3'd0});
                        vs_next = vs_w;
                        if (di == 32'd7)
                        begin
                            if (tag_reg == tcep_pkg::TAG_OFFT)
                            begin
                                bco_next = vs_w; seen_next[0] = 1'b1;
                            end
                            else
                            begin
                                bcs_next = vs_w; seen_next[1] = 1'b1;
                            end
                        end
                    end
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1)
                    begin
                        fbi_next = '0;
                        if (tag_reg == tcep_pkg::TAG_ENDT)
                        begin
                            nof_next = '0; nlen_next = '0; sraw_next = '0;
                            stg_next = '0; bco_next = '0; bcs_next = '0;
                            seen_next = '0;
                            phase_next = (done_cnt_reg >= total_reg) ? PH_DONE : PH_BOUNDARY;
                        end
                        else
                            phase_next = PH_HEAD;
                    end
                end
                default:
                begin
                end
            endcase

            if (!stop)
            begin
                pos_next = pos1[31:0];
                if (!rec && pos1 >= len33)
                begin
                    fin = 1'b1;
                    case (phase_next)
                        PH_HEADER:              st = tcep_pkg::ST_SHORT;
                        PH_SEEK:                st = tcep_pkg::ST_RANGE;
                        PH_COUNT:               st = tcep_pkg::ST_TABLE;
                        PH_BOUNDARY, PH_DONE:   st = tcep_pkg::ST_OK;
                        default:                st = tcep_pkg::ST_TRUNC;
                    endcase
                end
            end
            if (fin)
            begin
                fdone_next = 1'b1;
                out_c = '0;
                out_c.item_kind = 1'b1;
                out_c.status = st;
                out_c.record_count = (st == tcep_pkg::ST_OK) ? 11'(done_cnt_reg) : 11'd0;
            end
        end
        emit = fin || rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER; pos_reg <= '0; tab_reg <= '0;
            total_reg <= '0; done_cnt_reg <= '0; fbi_reg <= '0;
            tag_reg <= '0; flen_reg <= '0; skip_reg <= '0; vs_reg <= '0;
            nof_reg <= '0; nlen_reg <= '0; sraw_reg <= '0; stg_reg <= '0;
            seen_reg <= '0; bco_reg <= '0; bcs_reg <= '0; fdone_reg <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; pos_reg <= pos_next; tab_reg <= tab_next;
            total_reg <= total_next; done_cnt_reg <= done_cnt_next; fbi_reg <= fbi_next;
            tag_reg <= tag_next; flen_reg <= flen_next; skip_reg <= skip_next;
            vs_reg <= vs_next; nof_reg <= nof_next; nlen_reg <= nlen_next;
            sraw_reg <= sraw_next; stg_reg <= stg_next; seen_reg <= seen_next;
            bco_reg <= bco_next; bcs_reg <= bcs_next; fdone_reg <= fdone_next;
            res_valid <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            res <= out_c;
    end

endmodule

@@ sv/tcep_skid.sv @@
module tcep_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  tcep_pkg::result_t in_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output tcep_pkg::result_t out_data
);

    logic              full_reg, spare_reg;
    tcep_pkg::result_t main_reg, spare_data_reg;

    assign out_valid = full_reg;
    assign out_data  = main_reg;
    assign space     = !spare_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= 1'b0;
            spare_reg <= 1'b0;
        end
        else
        begin
            if (!full_reg || out_ready)
            begin
                full_reg  <= spare_reg || in_valid;
                spare_reg <= spare_reg && in_valid;
            end
            else if (in_valid)
                spare_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!full_reg || out_ready)
        begin
            if (spare_reg)
            begin
                main_reg <= spare_data_reg;
                if (in_valid)
                    spare_data_reg <= in_data;
            end
            else
                main_reg <= in_data;
        end
        else if (in_valid)
            spare_data_reg <= in_data;
    end

endmodule

@@ sv/tagged_container_entry_parser.sv @@
// Tagged container entry parser.
// The container file streams in on the slave channel, one byte per beat in
// s_tdata, after its total length has been written through cfg_we/cfg_wdata.
// Each accepted beat is parsed in the cycle it is taken, so the block accepts
// one byte every cycle while s_tready is high. A beat that ends an entry
// (fourth byte of its end tag) or ends the file produces one result beat
// on the master channel, registered in the parse stage and then in the output
// stage. Beats that produce nothing leave no trace on the master side.
// m_tuser is the item kind: 0 for an entry record, 1 for the final status.
// The final item comes at the last file byte or at the first error; later
// bytes are accepted and dropped until reset.
// When the receiver stalls, up to two results are held in a two-deep output
// buffer. s_tready is low while the spare slot is in use, and also in a cycle
// where a fresh result leaves the parse stage while the master beat is held
// off; it comes back as soon as the receiver takes a beat.
// Reset (rst_n low, asynchronous) returns the parser to the header phase,
// empties the output buffer and sets the file length register to 1.
module tagged_container_entry_parser #(
    parameter int NAME_CAPACITY = tcep_pkg::NAME_CAPACITY_DEF,
    parameter int MAX_ENTRIES   = tcep_pkg::MAX_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_index, name_offset, name_length, stage, type_byte, bitcode_valid,
    // bitcode_offset, bitcode_length, status, record_count, then 6 zero bits
    output logic [207:0] m_tdata,
    output logic         m_tuser    // item_kind
);

    logic [31:0]       file_length_reg;
    logic              step, core_valid, space;
    tcep_pkg::result_t core_res, out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            file_length_reg <= 32'd1;
        else if (cfg_we)
            file_length_reg <= cfg_wdata;
    end

    // The spare slot must be free: a result from the core is then always
    // taken, since the core holds at most one result in flight.
    assign s_tready = space && !(core_valid && m_tvalid && !m_tready);
    assign step     = s_tvalid && s_tready;

    tcep_core #(
        .NAME_CAPACITY (NAME_CAPACITY),
        .MAX_ENTRIES   (MAX_ENTRIES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (s_tdata),
        .file_length (file_length_reg),
        .res_valid   (core_valid),
        .res         (core_res)
    );

    tcep_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_valid),
        .in_data   (core_res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.item_kind;
    assign m_tdata = {6'd0, out_res.record_count, out_res.status,
                      out_res.bitcode_length, out_res.bitcode_offset,
                      out_res.bitcode_valid, out_res.type_byte, out_res.stage,
                      out_res.name_length, out_res.name_offset, out_res.entry_index};

endmodule
